/* hw/rtl/ssp_pkg.sv */
// ============================================================================
// ssp_pkg: shared types and constants for sprite screen projection
// Item and result structs, register indexes, reset values, fixed widths.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

	localparam int FRAC_BITS_DEF = 8;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int WIN_W      = 13;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 4'd1;

	localparam logic [WIN_W-1:0] WINDOW_WIDTH_RST  = 13'd640;
	localparam logic [WIN_W-1:0] WINDOW_HEIGHT_RST = 13'd480;

	localparam int VOFF_NUM   = 96;
	localparam int VOFF_NUM_W = 7;

	localparam int DET_MAG_W = 33;
	localparam int TNY_MAG_W = 34;
	localparam int COL_NUM_W = 47;
	localparam int QUO_W     = 16;

	typedef struct packed {
		logic signed [15:0] camera_x;
		logic signed [15:0] camera_y;
		logic signed [15:0] view_dir_x;
		logic signed [15:0] view_dir_y;
		logic signed [15:0] view_plane_x;
		logic signed [15:0] view_plane_y;
		logic signed [15:0] object_x;
		logic signed [15:0] object_y;
	} item_t;

	typedef struct packed {
		logic               visible;
		logic        [15:0] depth;
		logic signed [15:0] screen_column;
		logic        [15:0] sprite_size;
		logic        [14:0] vertical_offset;
		logic signed [15:0] start_x;
		logic signed [15:0] end_x;
		logic        [14:0] start_y;
		logic signed [15:0] end_y;
	} result_t;

	typedef struct packed {
		logic                 vis;
		logic                 neg_col;
		logic [DET_MAG_W-1:0] det_mag;
		logic [TNY_MAG_W-1:0] tny_mag;
		logic [COL_NUM_W-1:0] col_num;
	} xf_t;

endpackage

`default_nettype wire

/* hw/rtl/ssp_div.sv */
// ============================================================================
// ssp_div: pipelined unsigned restoring divider
// One quotient bit per stage, saturating quotient, tag carried alongside.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ssp_div #(
	parameter int NW = 34,
	parameter int DW = 33,
	parameter int QW = 16,
	parameter int TW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [TW-1:0] tag,
	output logic               out_valid,
	output logic      [QW-1:0] quo,
	output logic      [TW-1:0] out_tag
);

	localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic          vld_s [0:QW];
	logic [CW-1:0] rem_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic [QW-1:0] q_s   [0:QW];
	logic          ovf_s [0:QW];
	logic [TW-1:0] tag_s [0:QW];

	logic [CW-1:0] num_ext;
	logic [CW-1:0] den_top;

	assign num_ext = {{(CW-NW){1'b0}}, num};
	assign den_top = {{(CW-DW){1'b0}}, den} << QW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= num_ext;
		den_s[0] <= den;
		q_s[0]   <= '0;
		ovf_s[0] <= (num_ext >= den_top);
		tag_s[0] <= tag;
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		localparam int I = QW - k;
		logic [CW-1:0] sub;
		logic          ge;

		assign sub = {{(CW-DW){1'b0}}, den_s[k-1]} << I;
		assign ge  = (rem_s[k-1] >= sub);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? (rem_s[k-1] - sub) : rem_s[k-1];
			den_s[k] <= den_s[k-1];
			q_s[k]   <= q_s[k-1] | ({{(QW-1){1'b0}}, ge} << I);
			ovf_s[k] <= ovf_s[k-1];
			tag_s[k] <= tag_s[k-1];
		end
	end

	assign out_valid = vld_s[QW];
	assign quo       = ovf_s[QW] ? '1 : q_s[QW];
	assign out_tag   = tag_s[QW];

endmodule

`default_nettype wire

/* hw/rtl/ssp_xform.sv */
// ============================================================================
// ssp_xform: camera-space transform
// Relative position, cross products, visibility test and divider operands.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ssp_xform (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire ssp_pkg::item_t item,
	input  wire logic    [11:0] half_w,
	output logic                out_valid,
	output ssp_pkg::xf_t        xf
);

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic signed [16:0] sx_s1, sy_s1;
	logic signed [15:0] dx_s1, dy_s1, px_s1, py_s1;

	logic signed [31:0] pxdy_s2, dxpy_s2;
	logic signed [32:0] dysx_s2, dxsy_s2, pxsy_s2, pysx_s2;

	logic signed [32:0] det_s3;
	logic signed [33:0] tnx_s3, tny_s3;

	logic               vis_s4, neg_s4;
	logic        [32:0] detm_s4;
	logic        [33:0] tnym_s4;
	logic        [34:0] summ_s4;

	logic signed [34:0] sum3;
	ssp_pkg::xf_t       xf_s5;

	assign sum3 = 35'(tny_s3) + 35'(tnx_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		sx_s1 <= 17'(item.object_x) - 17'(item.camera_x);
		sy_s1 <= 17'(item.object_y) - 17'(item.camera_y);
		dx_s1 <= item.view_dir_x;
		dy_s1 <= item.view_dir_y;
		px_s1 <= item.view_plane_x;
		py_s1 <= item.view_plane_y;

		pxdy_s2 <= px_s1 * dy_s1;
		dxpy_s2 <= dx_s1 * py_s1;
		dysx_s2 <= 33'(dy_s1) * 33'(sx_s1);
		dxsy_s2 <= 33'(dx_s1) * 33'(sy_s1);
		pxsy_s2 <= 33'(px_s1) * 33'(sy_s1);
		pysx_s2 <= 33'(py_s1) * 33'(sx_s1);

		det_s3 <= 33'(pxdy_s2) - 33'(dxpy_s2);
		tnx_s3 <= 34'(dysx_s2) - 34'(dxsy_s2);
		tny_s3 <= 34'(pxsy_s2) - 34'(pysx_s2);

		vis_s4  <= (det_s3 != '0) && (tny_s3 != '0) && (det_s3[32] == tny_s3[33]);
		neg_s4  <= sum3[34] ^ tny_s3[33];
		detm_s4 <= det_s3[32] ? 33'(-det_s3) : 33'(det_s3);
		tnym_s4 <= tny_s3[33] ? 34'(-tny_s3) : 34'(tny_s3);
		summ_s4 <= sum3[34] ? 35'(-sum3) : 35'(sum3);

		xf_s5.vis     <= vis_s4;
		xf_s5.neg_col <= neg_s4;
		xf_s5.det_mag <= detm_s4;
		xf_s5.tny_mag <= tnym_s4;
		xf_s5.col_num <= 47'(half_w) * 47'(summ_s4);
	end

	assign out_valid = vld_s5;
	assign xf        = xf_s5;

endmodule

`default_nettype wire

/* hw/rtl/ssp_bounds.sv */
// ============================================================================
// ssp_bounds: drawing bounds and result register
// Clamp offset, derive clipped row and column bounds, zero hidden sprites.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ssp_bounds (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               vis,
	input  wire logic        [15:0] depth,
	input  wire logic signed [15:0] col,
	input  wire logic        [15:0] size,
	input  wire logic        [15:0] voff_raw,
	input  wire logic        [12:0] win_w,
	input  wire logic        [12:0] win_h,
	output logic                    done,
	output ssp_pkg::result_t        result
);

	logic        [14:0] voff;
	logic signed [18:0] half_s, half_h, col_e, w_e, h_e;
	logic signed [18:0] sy0, ey0, sx0, ex0;
	logic        [14:0] sy0_c;
	logic signed [15:0] ey0_c, sx0_c, ex0_c;
	logic               done_q;
	ssp_pkg::result_t   res_q, res_d;

	assign voff   = (voff_raw > 16'd32767) ? 15'h7FFF : voff_raw[14:0];
	assign half_s = 19'({3'b000, size[15:1]});
	assign half_h = 19'({7'b0000000, win_h[12:1]});
	assign col_e  = 19'(col);
	assign w_e    = 19'({6'b000000, win_w});
	assign h_e    = 19'({6'b000000, win_h});

	assign sy0 = half_h + 19'({4'b0000, voff}) - half_s;
	assign ey0 = half_s + half_h + 19'({4'b0000, voff});
	assign sx0 = col_e - half_s;
	assign ex0 = col_e + half_s;

	assign sy0_c = sy0[18] ? '0 : ((sy0 > 19'sd32767) ? 15'h7FFF : sy0[14:0]);
	assign ey0_c = (ey0 >= h_e) ? 16'(h_e - 19'sd1) : ey0[15:0];
	assign sx0_c = sx0[18] ? '0 : sx0[15:0];
	assign ex0_c = (ex0 >= w_e) ? 16'(w_e - 19'sd1) : ex0[15:0];

	always_comb begin
		res_d = '0;
		if (vis) begin
			res_d.visible         = 1'b1;
			res_d.depth           = depth;
			res_d.screen_column   = col;
			res_d.sprite_size     = size;
			res_d.vertical_offset = voff;
			res_d.start_x         = sx0_c;
			res_d.end_x           = ex0_c;
			res_d.start_y         = sy0_c;
			res_d.end_y           = ey0_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

/* hw/rtl/sprite_screen_projection.sv */
// ============================================================================
// sprite_screen_projection: sprite projection for a ray-casting renderer
// Stages from start to done: 5 transform, 2 x 17 divide, 1 bounds.
// Throughput: one item per cycle; busy stays low, every stage advances each cycle.
// Two layers of one-bit-per-stage dividers: depth and column, then offset and size.
// Reset: pipeline valids clear, window registers return to 640 x 480.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sprite_screen_projection #(
	parameter int FRAC_BITS = ssp_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire ssp_pkg::item_t                 item,
	output logic                                done,
	output ssp_pkg::result_t                    result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DNW = ssp_pkg::TNY_MAG_W + FRAC_BITS;
	localparam int VNW = ssp_pkg::VOFF_NUM_W + FRAC_BITS;
	localparam int SNW = ssp_pkg::WIN_W + FRAC_BITS;
	localparam int QW  = ssp_pkg::QUO_W;

	logic [ssp_pkg::WIN_W-1:0] win_w_q, win_h_q;

	logic         xf_valid;
	ssp_pkg::xf_t xf;

	logic          dd_valid, cd_valid, dd_vis, cd_neg;
	logic [QW-1:0] dq, cq;

	logic               vis2;
	logic signed [15:0] col_c;

	logic          vd_valid, sd_valid, vd_vis;
	logic [QW-1:0] voff_q, size_q;
	logic [31:0]   sd_tag;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_w_q <= ssp_pkg::WINDOW_WIDTH_RST;
			win_h_q <= ssp_pkg::WINDOW_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ssp_pkg::REG_WINDOW_WIDTH:  win_w_q <= cfg_data[ssp_pkg::WIN_W-1:0];
				ssp_pkg::REG_WINDOW_HEIGHT: win_h_q <= cfg_data[ssp_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	ssp_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.item      (item),
		.half_w    (win_w_q[12:1]),
		.out_valid (xf_valid),
		.xf        (xf)
	);

	ssp_div #(.NW(DNW), .DW(ssp_pkg::DET_MAG_W), .QW(QW), .TW(1)) u_depth_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (xf_valid),
		.num       ({xf.tny_mag, {FRAC_BITS{1'b0}}}),
		.den       (xf.det_mag),
		.tag       (xf.vis),
		.out_valid (dd_valid),
		.quo       (dq),
		.out_tag   (dd_vis)
	);

	ssp_div #(.NW(ssp_pkg::COL_NUM_W), .DW(ssp_pkg::TNY_MAG_W), .QW(QW), .TW(1)) u_col_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (xf_valid),
		.num       (xf.col_num),
		.den       (xf.tny_mag),
		.tag       (xf.neg_col),
		.out_valid (cd_valid),
		.quo       (cq),
		.out_tag   (cd_neg)
	);

	assign vis2 = dd_vis && (dq != '0);

	always_comb begin
		if (cd_neg) begin
			col_c = (cq > 16'd32768) ? 16'sh8000 : 16'(-cq);
		end else begin
			col_c = (cq > 16'd32767) ? 16'sh7FFF : cq;
		end
	end

	ssp_div #(.NW(VNW), .DW(QW), .QW(QW), .TW(1)) u_voff_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dd_valid && cd_valid),
		.num       (VNW'(ssp_pkg::VOFF_NUM) << FRAC_BITS),
		.den       (dq),
		.tag       (vis2),
		.out_valid (vd_valid),
		.quo       (voff_q),
		.out_tag   (vd_vis)
	);

	ssp_div #(.NW(SNW), .DW(QW), .QW(QW), .TW(32)) u_size_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dd_valid && cd_valid),
		.num       ({win_h_q, {FRAC_BITS{1'b0}}}),
		.den       (dq),
		.tag       ({dq, col_c}),
		.out_valid (sd_valid),
		.quo       (size_q),
		.out_tag   (sd_tag)
	);

	ssp_bounds u_bounds (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vd_valid && sd_valid),
		.vis      (vd_vis),
		.depth    (sd_tag[31:16]),
		.col      (sd_tag[15:0]),
		.size     (size_q),
		.voff_raw (voff_q),
		.win_w    (win_w_q),
		.win_h    (win_h_q),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire
